// File: src/nmea_sentence_field_decoder_unit_macros.svh
// Assertion macros for the NMEA sentence field decoder unit.
`ifndef NMEA_SENTENCE_FIELD_DECODER_UNIT_MACROS_SVH
`define NMEA_SENTENCE_FIELD_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define NSFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSFD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/nsfd_pkg.sv
// Shared types, constants and character decode functions for the NMEA field decoder.
package nsfd_pkg;

  localparam int MAX_SENTENCE_LEN_DEF = 128;
  localparam int FIFO_DEPTH = 4;
  localparam int IN_W = 8;
  localparam int VAL_W = 13;
  localparam int NUM_VALS = 10;
  localparam int FAIL_W = 16;
  localparam int STATUS_W = 2;
  localparam int OUT_BITS = STATUS_W + NUM_VALS * VAL_W + FAIL_W;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int HDR_LEN = 7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    ST_IMU   = 2'd0,
    ST_OTHER = 2'd1,
    ST_FAIL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_dollar;
    logic       is_lf;
    logic       is_star;
    logic       is_comma;
    logic       sx_bad;
    logic [5:0] sx;
    logic       hx_bad;
    logic [3:0] hx;
  } cls_t;

  // base-64 sextet; bit 6 set = bad character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b0, 6'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd36)};
    end else if (c == 8'h5B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h5D) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

  // hex digit; bit 4 set = not a hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

  // "$PITRI,"
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = CH_DOLLAR;
      3'd1: r = 8'h50;
      3'd2: r = 8'h49;
      3'd3: r = 8'h54;
      3'd4: r = 8'h52;
      3'd5: r = 8'h49;
      3'd6: r = CH_COMMA;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: src/nsfd_front.sv
// Front end: accepts received characters and classifies them for the sentence engine.
module nsfd_front (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,  // [7:0] rx_byte
  input  logic                  q_full,
  output logic                  push,
  output nsfd_pkg::cls_t        cls
);

  logic [6:0] sx;
  logic [4:0] hx;

  assign s_tready = !q_full;
  assign push = s_tvalid && !q_full;

  always_comb begin
    sx = nsfd_pkg::sextet_of(s_tdata);
    hx = nsfd_pkg::hex_of(s_tdata);
    cls.ch = s_tdata;
    cls.is_dollar = (s_tdata == nsfd_pkg::CH_DOLLAR);
    cls.is_lf = (s_tdata == nsfd_pkg::CH_LF);
    cls.is_star = (s_tdata == nsfd_pkg::CH_STAR);
    cls.is_comma = (s_tdata == nsfd_pkg::CH_COMMA);
    cls.sx_bad = sx[6];
    cls.sx = sx[5:0];
    cls.hx_bad = hx[4];
    cls.hx = hx[3:0];
  end

endmodule

// File: src/nsfd_fifo.sv
// Short queue of classified characters between front end and sentence engine.
module nsfd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nsfd_pkg::cls_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output nsfd_pkg::cls_t rdata
);

  localparam int PTR_W = $clog2(nsfd_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(nsfd_pkg::FIFO_DEPTH + 1);

  nsfd_pkg::cls_t    mem [nsfd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;
  logic              do_pop;

  assign full = (count == CNT_W'(nsfd_pkg::FIFO_DEPTH));
  assign nonempty = (count != '0);
  assign do_pop = pop && nonempty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(nsfd_pkg::FIFO_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(nsfd_pkg::FIFO_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/nsfd_back.sv
// Sentence engine: checksum, header match, field decode and registered result.
module nsfd_back #(
  parameter int MAX_SENTENCE_LEN = nsfd_pkg::MAX_SENTENCE_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_nonempty,
  input  nsfd_pkg::cls_t             q_data,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [nsfd_pkg::OUT_W-1:0] m_tdata
);

  localparam int PW = $clog2(MAX_SENTENCE_LEN);
  localparam int VW = nsfd_pkg::VAL_W;
  localparam int SW = $clog2(nsfd_pkg::NUM_VALS);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_BODY,
    PH_CKHI,
    PH_CKLO,
    PH_WAIT
  } phase_t;

  phase_t                       phase;
  logic [PW-1:0]                pos;
  logic [7:0]                   xr;
  logic                         hdr_ok;
  logic [3:0]                   fidx;
  logic [1:0]                   cif;
  logic                         hi_bad;
  logic [5:0]                   hi;
  logic [8:0]                   rck;
  logic [nsfd_pkg::FAIL_W-1:0]  fails;
  logic signed [VW-1:0]         vals [nsfd_pkg::NUM_VALS];

  logic [PW-1:0]                pos_next;
  logic                         ck_ok;
  logic [nsfd_pkg::FAIL_W-1:0]  fails_next;
  logic                         slot_hit;
  logic [SW-1:0]                slot;
  logic signed [VW-1:0]         val_next;
  logic [nsfd_pkg::OUT_W-1:0]   result;
  nsfd_pkg::status_t            status;

  assign pop = q_nonempty && (!m_tvalid || m_tready);

  always_comb begin
    pos_next = pos + PW'(1);
    ck_ok = (phase == PH_WAIT) && (rck == {1'b0, xr});
    fails_next = (fails == '1) ? fails : fails + nsfd_pkg::FAIL_W'(1);
    slot_hit = (fidx <= 4'd8) || (fidx == 4'd12);
    slot = (fidx == 4'd12) ? SW'(9) : SW'(fidx);
    val_next = (hi_bad || q_data.sx_bad) ? '1 : {1'b0, hi, q_data.sx};
    if (!ck_ok) begin
      status = nsfd_pkg::ST_FAIL;
    end else if (hdr_ok) begin
      status = nsfd_pkg::ST_IMU;
    end else begin
      status = nsfd_pkg::ST_OTHER;
    end
    result = '0;
    result[nsfd_pkg::STATUS_W-1:0] = status;
    if (status == nsfd_pkg::ST_IMU) begin
      for (int i = 0; i < nsfd_pkg::NUM_VALS; i++) begin
        result[nsfd_pkg::STATUS_W + i*VW +: VW] = vals[i];
      end
    end
    result[nsfd_pkg::STATUS_W + nsfd_pkg::NUM_VALS*VW +: nsfd_pkg::FAIL_W] =
      ck_ok ? fails : fails_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      m_tvalid <= 1'b0;
      fails <= '0;
      pos <= '0;
      xr <= '0;
      hdr_ok <= 1'b1;
      fidx <= '0;
      cif <= '0;
      hi_bad <= 1'b0;
      hi <= '0;
      rck <= '0;
      for (int i = 0; i < nsfd_pkg::NUM_VALS; i++) begin
        vals[i] <= '1;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        if (q_data.is_dollar) begin
          phase <= PH_BODY;
          pos <= '0;
          xr <= '0;
          hdr_ok <= 1'b1;
          fidx <= '0;
          cif <= '0;
          hi_bad <= 1'b0;
          hi <= '0;
          rck <= '0;
          for (int i = 0; i < nsfd_pkg::NUM_VALS; i++) begin
            vals[i] <= '1;
          end
        end else if (phase != PH_HUNT) begin
          pos <= pos_next;
          if (q_data.is_lf) begin
            m_tvalid <= 1'b1;
            m_tdata <= result;
            if (!ck_ok) begin
              fails <= fails_next;
            end
            phase <= PH_HUNT;
          end else begin
            unique case (phase)
              PH_BODY: begin
                if (q_data.is_star) begin
                  if (pos_next < PW'(nsfd_pkg::HDR_LEN + 1)) begin
                    hdr_ok <= 1'b0;
                  end
                  phase <= PH_CKHI;
                end else begin
                  xr <= xr ^ q_data.ch;
                  if (pos_next < PW'(nsfd_pkg::HDR_LEN)) begin
                    if (q_data.ch != nsfd_pkg::hdr_char(pos_next[2:0])) begin
                      hdr_ok <= 1'b0;
                    end
                  end else if (hdr_ok) begin
                    if (q_data.is_comma) begin
                      if (fidx != 4'd15) begin
                        fidx <= fidx + 4'd1;
                      end
                      cif <= 2'd0;
                    end else if (cif == 2'd0) begin
                      hi_bad <= q_data.sx_bad;
                      hi <= q_data.sx;
                      cif <= 2'd1;
                    end else if (cif == 2'd1) begin
                      if (slot_hit) begin
                        vals[slot] <= val_next;
                      end
                      cif <= 2'd2;
                    end
                  end
                end
              end
              PH_CKHI: begin
                rck <= {q_data.hx_bad, q_data.hx, 4'b0000};
                phase <= PH_CKLO;
              end
              PH_CKLO: begin
                rck <= (rck[8] || q_data.hx_bad) ? 9'h100 : {1'b0, rck[7:4], q_data.hx};
                phase <= PH_WAIT;
              end
              default: begin
              end
            endcase
            if (pos_next >= PW'(MAX_SENTENCE_LEN - 1)) begin
              phase <= PH_HUNT;
            end
          end
        end
      end
    end
  end

endmodule

// File: src/nmea_sentence_field_decoder_unit.sv
// Top level of the NMEA sentence field decoder: front end, queue and sentence engine.
// Throughput: one character per cycle, unless the output stalls until its register drains.
// A result is registered at the engine output after its line feed has passed the queue.
// A stalled output holds the engine; the four-entry queue then fills before s_tready drops.
// Synchronous reset clears the engine to hunting, the queue to empty, the fail count to zero.
module nmea_sentence_field_decoder_unit #(
  parameter int MAX_SENTENCE_LEN = nsfd_pkg::MAX_SENTENCE_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,  // [7:0] rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [1:0] status, [14:2] accel_x, [27:15] accel_y, [40:28] accel_z,
  // [53:41] gyro_x, [66:54] gyro_y, [79:67] gyro_z, [92:80] mag_x,
  // [105:93] mag_y, [118:106] mag_z, [131:119] sample_time,
  // [147:132] fail_count, [151:148] zero
  output logic [nsfd_pkg::OUT_W-1:0] m_tdata
);

  nsfd_pkg::cls_t cls;
  nsfd_pkg::cls_t q_data;
  logic           push;
  logic           q_full;
  logic           q_nonempty;
  logic           pop;

  nsfd_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .cls      (cls)
  );

  nsfd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (cls),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .rdata    (q_data)
  );

  nsfd_back #(
    .MAX_SENTENCE_LEN (MAX_SENTENCE_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_data     (q_data),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// File: src/nsfd_checker.sv
// Port-level checks for the NMEA sentence field decoder, bound to the top level.
`include "nmea_sentence_field_decoder_unit_macros.svh"

module nsfd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [7:0]                 s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [nsfd_pkg::OUT_W-1:0] m_tdata
);

  logic in_take;
  assign in_take = s_tvalid && s_tready && (s_tdata != 8'h00);

  `NSFD_ASSERT_NXT(a_rst_idle, clk, 1'b0, rst, !m_tvalid, "result valid right after reset")
  `NSFD_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  `NSFD_ASSERT_IMP(a_zero_vals, clk, rst, m_tvalid && (m_tdata[1:0] != 2'd0) && (in_take || !in_take), m_tdata[131:2] == '0, "value fields set on non-IMU result")
  `NSFD_ASSERT_IMP(a_fail_cnt, clk, rst, m_tvalid && (m_tdata[1:0] == 2'd2), m_tdata[147:132] != 16'd0, "failed checksum with zero fail count")
  `NSFD_ASSERT_IMP(a_val_form, clk, rst, m_tvalid && m_tdata[14], m_tdata[14:2] == 13'h1fff, "decoded value out of range")

endmodule

bind nmea_sentence_field_decoder_unit nsfd_checker u_nsfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
